[hw/rtl/hsv_component_replace_assert.svh]
// ----------------------------------------------------------------------------
// HSV component replace assertion macros
// Concurrent assertion wrappers clocked on i_clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef HSV_COMPONENT_REPLACE_ASSERT_SVH
`define HSV_COMPONENT_REPLACE_ASSERT_SVH

`ifndef ASSERT_OFF
// check prop at every edge outside reset
`define HCR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("hsv_component_replace assertion failed");
// check prop at every edge, reset included
`define HCR_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("hsv_component_replace assertion failed");
`else
`define HCR_ASSERT(lbl, prop)
`define HCR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[hw/rtl/hcr_pkg.sv]
// ----------------------------------------------------------------------------
// HSV component replace package
// Fixed-point widths, constants, register codes and replacement tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hcr_pkg;

    localparam int F  = 16;      // fractional bits
    localparam int QW = F + 2;   // hue quotient, [0, 2*one]
    localparam int SW = F + 1;   // saturation, [0, one]
    localparam int HW = F + 3;   // hue in sectors, [0, 6*one)
    localparam int VW = F + 8;   // value in byte units

    localparam logic [SW-1:0] ONE_S = {1'b1, {F{1'b0}}};
    localparam logic [HW-1:0] ONE_H = {3'b001, {F{1'b0}}};
    localparam logic [HW-1:0] SIX_H = {3'b110, {F{1'b0}}};

    localparam logic [1:0] MODE_HUE = 2'd0;
    localparam logic [1:0] MODE_SAT = 2'd1;
    localparam logic [1:0] MODE_VAL = 2'd2;
    localparam logic [1:0] MODE_RSV = 2'd3;

    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_HUE  = 2'd1;
    localparam logic [1:0] CFG_SAT  = 2'd2;
    localparam logic [1:0] CFG_VAL  = 2'd3;

    localparam logic [1:0] BASE_R = 2'd0;
    localparam logic [1:0] BASE_G = 2'd1;
    localparam logic [1:0] BASE_B = 2'd2;

    // one divider cell's view of a pixel
    typedef struct packed {
        logic [QW-1:0] hq;     // hue quotient, bits shifted in from the right
        logic [7:0]    hr;     // hue partial remainder
        logic [SW-1:0] sq;     // saturation quotient
        logic [7:0]    sr;     // saturation partial remainder
        logic [7:0]    delta;
        logic [7:0]    mx;
        logic [1:0]    base;
        logic          dz;     // grey pixel
    } t_cell;

    typedef struct packed {
        logic [1:0]    mode;
        logic [HW-1:0] h;
        logic [SW-1:0] s;
        logic [VW-1:0] v;
    } t_rep;

    typedef logic [F-1:0]  t_hue_tab [0:59];
    typedef logic [SW-1:0] t_sat_tab [0:100];
    typedef logic [VW-1:0] t_val_tab [0:100];

    function automatic t_hue_tab f_hue_tab();
        t_hue_tab   t;
        logic [63:0] w;
        for (int i = 0; i < 60; i++) begin
            w = (64'(i) << F) / 60;
            t[i] = w[F-1:0];
        end
        return t;
    endfunction

    function automatic t_sat_tab f_sat_tab();
        t_sat_tab   t;
        logic [63:0] w;
        for (int i = 0; i <= 100; i++) begin
            w = (64'(i) << F) / 100;
            t[i] = w[SW-1:0];
        end
        return t;
    endfunction

    function automatic t_val_tab f_val_tab();
        t_val_tab   t;
        logic [63:0] w;
        for (int i = 0; i <= 100; i++) begin
            w = (64'(i * 255) << F) / 100;
            t[i] = w[VW-1:0];
        end
        return t;
    endfunction

    localparam t_hue_tab HUE_TAB = f_hue_tab();
    localparam t_sat_tab SAT_TAB = f_sat_tab();
    localparam t_val_tab VAL_TAB = f_val_tab();

endpackage

`default_nettype wire

[hw/rtl/hcr_cell.sv]
// ----------------------------------------------------------------------------
// HSV component replace divider cell
// Produces one fraction bit of the hue and the saturation quotient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hcr_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire hcr_pkg::t_cell i_d,
    output logic               o_vld,
    output hcr_pkg::t_cell     o_d
);
    import hcr_pkg::*;

    logic   r_vld;
    t_cell  r_d;
    t_cell  n_d;
    logic [8:0] w_h2;
    logic [8:0] w_s2;
    logic       w_hb;
    logic       w_sb;
    logic [8:0] w_hsub;
    logic [8:0] w_ssub;

    always_comb begin
        w_h2   = {i_d.hr, 1'b0};
        w_s2   = {i_d.sr, 1'b0};
        w_hb   = w_h2 >= {1'b0, i_d.delta};
        w_sb   = w_s2 >= {1'b0, i_d.mx};
        w_hsub = w_h2 - {1'b0, i_d.delta};
        w_ssub = w_s2 - {1'b0, i_d.mx};
        n_d    = i_d;
        n_d.hr = w_hb ? w_hsub[7:0] : w_h2[7:0];
        n_d.sr = w_sb ? w_ssub[7:0] : w_s2[7:0];
        n_d.hq = {i_d.hq[QW-2:0], w_hb};
        n_d.sq = {i_d.sq[SW-2:0], w_sb};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule

`default_nettype wire

[hw/rtl/hcr_recon.sv]
// ----------------------------------------------------------------------------
// HSV component replace back conversion
// Replace one component, then rebuild RGB through the multiplier stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hcr_recon (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire hcr_pkg::t_rep  i_rep,
    input  wire logic           i_vld,
    input  wire hcr_pkg::t_cell i_d,
    output logic                o_ready,
    output logic                o_vld,
    output logic [23:0]         o_rgb,
    input  wire logic           i_ready
);
    import hcr_pkg::*;

    // stage A: hue, saturation, value
    logic          r_a_vld;
    logic [HW-1:0] r_a_hh;
    logic [SW-1:0] r_a_ss;
    logic [VW-1:0] r_a_vv;
    // stage B: cross terms
    logic          r_b_vld;
    logic [2:0]    r_b_n;
    logic [SW-1:0] r_b_fs;
    logic [SW-1:0] r_b_gs;
    logic [VW-1:0] r_b_vv;
    logic [7:0]    r_b_p;
    // stage C: channel candidates
    logic          r_c_vld;
    logic [2:0]    r_c_n;
    logic [7:0]    r_c_l;
    logic [7:0]    r_c_p;
    logic [7:0]    r_c_q;
    logic [7:0]    r_c_u;
    // stage D: output
    logic          r_d_vld;
    logic [23:0]   r_d_rgb;

    logic w_en_a, w_en_b, w_en_c, w_en_d;

    assign w_en_d  = !r_d_vld || i_ready;
    assign w_en_c  = !r_c_vld || w_en_d;
    assign w_en_b  = !r_b_vld || w_en_c;
    assign w_en_a  = !r_a_vld || w_en_b;
    assign o_ready = w_en_a;

    // stage A
    logic [HW-1:0] w_hsum;
    logic [HW-1:0] w_hwrap;
    logic [HW-1:0] n_a_hh;
    logic [SW-1:0] n_a_ss;
    logic [VW-1:0] n_a_vv;

    always_comb begin
        w_hsum  = {i_d.base, 1'b0, {F{1'b0}}} + {1'b0, i_d.hq};
        w_hwrap = (w_hsum < ONE_H) ? w_hsum + SIX_H : w_hsum;
        n_a_hh  = i_d.dz ? '0 : w_hwrap - ONE_H;
        n_a_ss  = i_d.dz ? '0 : i_d.sq;
        n_a_vv  = {i_d.mx, {F{1'b0}}};
        unique case (i_rep.mode)
            MODE_HUE: n_a_hh = i_rep.h;
            MODE_SAT: n_a_ss = i_rep.s;
            MODE_VAL: n_a_vv = i_rep.v;
            default:  n_a_vv = i_rep.v;
        endcase
    end

    // stage B
    logic [F-1:0]     w_f;
    logic [SW-1:0]    w_omf;
    logic [F+SW-1:0]  w_fsp;
    logic [2*SW-1:0]  w_gsp;
    logic [VW+SW-1:0] w_pp;

    always_comb begin
        w_f   = r_a_hh[F-1:0];
        w_omf = ONE_S - {1'b0, w_f};
        w_fsp = (F+SW)'(w_f) * (F+SW)'(r_a_ss);
        w_gsp = (2*SW)'(w_omf) * (2*SW)'(r_a_ss);
        w_pp  = (VW+SW)'(r_a_vv) * (VW+SW)'(ONE_S - r_a_ss);
    end

    // stage C
    logic [VW+SW-1:0] w_qp;
    logic [VW+SW-1:0] w_up;

    always_comb begin
        w_qp = (VW+SW)'(r_b_vv) * (VW+SW)'(ONE_S - r_b_fs);
        w_up = (VW+SW)'(r_b_vv) * (VW+SW)'(ONE_S - r_b_gs);
    end

    // stage D: sector select
    logic [23:0] n_d_rgb;

    always_comb begin
        unique case (r_c_n)
            3'd0:    n_d_rgb = {r_c_p, r_c_u, r_c_l};
            3'd1:    n_d_rgb = {r_c_p, r_c_l, r_c_q};
            3'd2:    n_d_rgb = {r_c_u, r_c_l, r_c_p};
            3'd3:    n_d_rgb = {r_c_l, r_c_q, r_c_p};
            3'd4:    n_d_rgb = {r_c_l, r_c_p, r_c_u};
            default: n_d_rgb = {r_c_q, r_c_p, r_c_l};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            if (w_en_a) r_a_vld <= i_vld;
            if (w_en_b) r_b_vld <= r_a_vld;
            if (w_en_c) r_c_vld <= r_b_vld;
            if (w_en_d) r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_a_hh <= n_a_hh;
            r_a_ss <= n_a_ss;
            r_a_vv <= n_a_vv;
        end
        if (w_en_b) begin
            r_b_n  <= r_a_hh[HW-1:F];
            r_b_fs <= w_fsp[F+SW-1:F];
            r_b_gs <= w_gsp[F+SW-1:F];
            r_b_vv <= r_a_vv;
            r_b_p  <= w_pp[2*F+7:2*F];
        end
        if (w_en_c) begin
            r_c_n <= r_b_n;
            r_c_l <= r_b_vv[VW-1:F];
            r_c_p <= r_b_p;
            r_c_q <= w_qp[2*F+7:2*F];
            r_c_u <= w_up[2*F+7:2*F];
        end
        if (w_en_d) begin
            r_d_rgb <= n_d_rgb;
        end
    end

    assign o_vld = r_d_vld;
    assign o_rgb = r_d_rgb;

endmodule

`default_nettype wire

[hw/rtl/hsv_component_replace.sv]
// ----------------------------------------------------------------------------
// HSV component replace
// Per-pixel RGB to HSV, replace one component, HSV back to RGB.
// ----------------------------------------------------------------------------
// Takes one RGB pixel per clock, unless the output stalls, and returns it
// with hue, saturation or value (chosen by the mode register) replaced by a
// configured constant. The block is fully pipelined: a new pixel is accepted
// every cycle unless output back-pressure has filled the pipeline. A pixel
// passes a head stage to find max, min and sector, one cell per fraction bit
// of the hue and saturation division chain, and four back-conversion stages
// built around the multipliers. Every stage holds its own valid bit, so the
// pipeline closes bubbles and keeps taking beats while a result waits at the
// output. Register writes take effect at once; write only while no pixel is
// in flight. Replacement constants are looked up when written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsv_component_replace (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write port
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [8:0]  i_cfg_data,
    // pixel in
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
    // pixel out
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata    // red_out[7:0], green_out[15:8], blue_out[23:16]
);
    import hcr_pkg::*;

    `include "hsv_component_replace_assert.svh"

    // ------------------------------------------------------------------
    // Configuration: clamp, then store replacement in fixed point
    // ------------------------------------------------------------------
    t_rep r_rep;
    logic [8:0] w_hue;
    logic [6:0] w_pct;
    logic [2:0] w_hsec;
    logic [8:0] w_hoff;
    logic [8:0] w_hrem;
    logic [1:0] w_mode;

    always_comb begin
        w_mode = (i_cfg_data[1:0] == MODE_RSV) ? MODE_VAL : i_cfg_data[1:0];
        w_hue  = (i_cfg_data > 9'd359) ? 9'd359 : i_cfg_data;
        w_pct  = (i_cfg_data[6:0] > 7'd100) ? 7'd100 : i_cfg_data[6:0];
        // split hue into whole sector and degrees within the sector
        priority if (w_hue >= 9'd300) begin
            w_hsec = 3'd5; w_hoff = 9'd300;
        end else if (w_hue >= 9'd240) begin
            w_hsec = 3'd4; w_hoff = 9'd240;
        end else if (w_hue >= 9'd180) begin
            w_hsec = 3'd3; w_hoff = 9'd180;
        end else if (w_hue >= 9'd120) begin
            w_hsec = 3'd2; w_hoff = 9'd120;
        end else if (w_hue >= 9'd60) begin
            w_hsec = 3'd1; w_hoff = 9'd60;
        end else begin
            w_hsec = 3'd0; w_hoff = 9'd0;
        end
        w_hrem = w_hue - w_hoff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep.mode <= MODE_HUE;
            r_rep.h    <= '0;
            r_rep.s    <= '0;
            r_rep.v    <= VAL_TAB[100];
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MODE: r_rep.mode <= w_mode;
                CFG_HUE:  r_rep.h    <= {w_hsec, HUE_TAB[w_hrem[5:0]]};
                CFG_SAT:  r_rep.s    <= SAT_TAB[w_pct];
                CFG_VAL:  r_rep.v    <= VAL_TAB[w_pct];
                default:  r_rep.v    <= VAL_TAB[w_pct];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Head stage: max, min, sector and integer parts of both quotients
    // ------------------------------------------------------------------
    logic [7:0] w_r, w_g, w_b, w_mx, w_mn, w_dl, w_a, w_c;
    logic [8:0] w_x, w_x1, w_x2;
    t_cell      n_h;
    t_cell      r_h;
    logic       r_h_vld;

    always_comb begin
        w_r  = i_s_tdata[7:0];
        w_g  = i_s_tdata[15:8];
        w_b  = i_s_tdata[23:16];
        w_mx = w_r;
        w_mn = w_r;
        if (w_g > w_mx) w_mx = w_g;
        if (w_b > w_mx) w_mx = w_b;
        if (w_g < w_mn) w_mn = w_g;
        if (w_b < w_mn) w_mn = w_b;
        w_dl = w_mx - w_mn;
        // ties go red, then green, then blue
        priority if (w_mx == w_r) begin
            w_a = w_g; w_c = w_b; n_h.base = BASE_R;
        end else if (w_mx == w_g) begin
            w_a = w_b; w_c = w_r; n_h.base = BASE_G;
        end else begin
            w_a = w_r; w_c = w_g; n_h.base = BASE_B;
        end
        // numerator shifted into [0, 2*delta]
        w_x  = {1'b0, w_a} + {1'b0, w_dl} - {1'b0, w_c};
        w_x1 = w_x - {1'b0, w_dl};
        w_x2 = w_x - {w_dl, 1'b0};
        priority if (w_x >= {w_dl, 1'b0}) begin
            n_h.hq = QW'(2);
            n_h.hr = w_x2[7:0];
        end else if (w_x >= {1'b0, w_dl}) begin
            n_h.hq = QW'(1);
            n_h.hr = w_x1[7:0];
        end else begin
            n_h.hq = '0;
            n_h.hr = w_x[7:0];
        end
        // delta never exceeds max; equal only for a saturated pixel
        if (w_dl == w_mx && w_mx != 8'd0) begin
            n_h.sq = SW'(1);
            n_h.sr = 8'd0;
        end else begin
            n_h.sq = '0;
            n_h.sr = w_dl;
        end
        n_h.delta = w_dl;
        n_h.mx    = w_mx;
        n_h.dz    = (w_dl == 8'd0);
    end

    // ------------------------------------------------------------------
    // Division chain: one cell per fraction bit
    // ------------------------------------------------------------------
    logic  w_vld [0:F-1];
    t_cell w_d   [0:F-1];
    logic  w_en  [0:F];
    logic  w_en_h;
    logic  w_rc_ready;

    assign w_en[F] = w_rc_ready;
    assign w_en_h  = !r_h_vld || w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else if (w_en_h) begin
            r_h_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_h) begin
            r_h <= n_h;
        end
    end

    for (genvar k = 0; k < F; k++) begin : g_cell
        // advance a cell when it is empty or its neighbor advances
        assign w_en[k] = !w_vld[k] || w_en[k+1];
        if (k == 0) begin : g_first
            hcr_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en[k]),
                .i_vld   (r_h_vld),
                .i_d     (r_h),
                .o_vld   (w_vld[k]),
                .o_d     (w_d[k])
            );
        end else begin : g_next
            hcr_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en[k]),
                .i_vld   (w_vld[k-1]),
                .i_d     (w_d[k-1]),
                .o_vld   (w_vld[k]),
                .o_d     (w_d[k])
            );
        end
    end

    // ------------------------------------------------------------------
    // Replace and convert back
    // ------------------------------------------------------------------
    hcr_recon u_recon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rep   (r_rep),
        .i_vld   (w_vld[F-1]),
        .i_d     (w_d[F-1]),
        .o_ready (w_rc_ready),
        .o_vld   (o_m_tvalid),
        .o_rgb   (o_m_tdata),
        .i_ready (i_m_tready)
    );

    assign o_s_tready = w_en_h;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // an accepted beat lands in the head stage
    `HCR_ASSERT(a_head_load, (i_s_tvalid && o_s_tready) |=> r_h_vld)
    // the reserved mode code never gets stored
    `HCR_ASSERT(a_mode_legal, r_rep.mode != MODE_RSV)
    // the replacement hue stays below six sectors
    `HCR_ASSERT(a_rep_hue, r_rep.h < SIX_H)
    // reset empties the output
    `HCR_ASSERT_ALWAYS(a_rst_out, !i_rst_n |=> !o_m_tvalid)

endmodule

`default_nettype wire

[sim/hsv_component_replace_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV component replace testbench
// Drives RGB pixels with random gaps and output stalls, predicts each pixel
// in fixed point and compares every output beat in order, channel by channel.
// ----------------------------------------------------------------------------
module hsv_component_replace_tb;
    import hcr_pkg::*;

    localparam int FB = 16;
    localparam longint ONE = 64'd1 << FB;
    localparam int LATENCY = FB + 5;
    localparam int LIMIT = 2000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = '0;
    logic [8:0]  i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;   // red[7:0], green[15:8], blue[23:16]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;        // red[7:0], green[15:8], blue[23:16]

    hsv_component_replace u_dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor copy of the registers
    logic [1:0] mode_q;
    logic [8:0] hue_q;
    logic [6:0] sat_q;
    logic [6:0] val_q;

    logic [23:0] pixel_q[$];
    int  errors = 0;
    int  cycles = 0;
    int  stall_left = 0;    // remaining cycles of a receiver idle burst
    bit  calm = 0;          // no idling in the last part
    bit  hold_off = 0;      // long receiver stall request

    typedef struct {
        logic [23:0] rgb;
        bit          known;
        logic [23:0] out;
    } t_row;

    function automatic logic [23:0] replace_pixel(logic [23:0] rgb);
        longint r, g, b, mx, mn, dl, hh, ss, vv, n, f, fs, gs, l, p, q, u;
        longint a, c, bs;
        longint o[3];
        r = rgb[7:0]; g = rgb[15:8]; b = rgb[23:16];
        mx = r; mn = r; hh = 0; ss = 0;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        dl = mx - mn;
        if (dl != 0) begin
            if (mx == r) begin a = g; c = b; bs = 0; end
            else if (mx == g) begin a = b; c = r; bs = 2; end
            else begin a = r; c = g; bs = 4; end
            hh = bs * ONE + ((a + dl - c) << FB) / dl;
            if (hh < ONE) hh += 6 * ONE;
            hh -= ONE;
        end
        if (mx != 0) ss = (dl << FB) / mx;
        vv = mx << FB;
        case (mode_q)
            MODE_HUE: hh = (longint'(hue_q) << FB) / 60;
            MODE_SAT: ss = (longint'(sat_q) << FB) / 100;
            default:  vv = ((longint'(val_q) * 255) << FB) / 100;
        endcase
        n = hh >> FB;
        f = hh & (ONE - 1);
        fs = (f * ss) >> FB;
        gs = ((ONE - f) * ss) >> FB;
        l = vv >> FB;
        p = (vv * (ONE - ss)) >> (2 * FB);
        q = (vv * (ONE - fs)) >> (2 * FB);
        u = (vv * (ONE - gs)) >> (2 * FB);
        case (n)
            0: o = '{l, u, p};
            1: o = '{q, l, p};
            2: o = '{p, l, u};
            3: o = '{p, q, l};
            4: o = '{u, p, l};
            default: o = '{l, p, q};
        endcase
        return {o[2][7:0], o[1][7:0], o[0][7:0]};
    endfunction

    // write one register; index and value go straight through, clamp in predictor
    task automatic write_reg(logic [1:0] idx, logic [8:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1; i_cfg_addr = idx; i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_MODE: mode_q = (data[1:0] > MODE_VAL) ? MODE_VAL : data[1:0];
            CFG_HUE:  hue_q  = (data > 9'd359) ? 9'd359 : data;
            CFG_SAT:  sat_q  = (data[6:0] > 7'd100) ? 7'd100 : data[6:0];
            default:  val_q  = (data[6:0] > 7'd100) ? 7'd100 : data[6:0];
        endcase
    endtask

    // offer one pixel beat, with optional random gap first; valid stays up
    // after the beat so the next pixel can follow back to back
    task automatic send_pixel(logic [23:0] rgb);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= rgb;
        pixel_q.push_back(replace_pixel(rgb));
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // drop valid and wait for the pipe to drain before touching registers
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    // random pixel: mostly full range, some greys and near-greys
    function automatic logic [23:0] rand_pixel();
        logic [7:0] k;
        k = 8'($urandom);
        case ($urandom_range(0, 7))
            0: return {k, k, k};
            1: return {k, k, 8'($urandom_range(0, 255))};
            2: return {8'(k + $urandom_range(0, 2)), k, 8'(k - $urandom_range(0, 2))};
            default: return 24'($urandom);
        endcase
    endfunction

    // receiver: random idle bursts, one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_off) begin
            i_m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left--;
        end else if (!calm && $urandom_range(0, 15) == 0) begin
            i_m_tready <= 1'b0;
            stall_left = $urandom_range(0, 15);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // check each output beat against the oldest prediction
    always @(posedge i_clk) begin
        logic [23:0] want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pixel_q.size() == 0) begin
                $error("output beat with no pixel pending: %h", o_m_tdata);
                errors++;
            end else begin
                want = pixel_q.pop_front();
                if (o_m_tdata[7:0] !== want[7:0]) begin
                    $error("red_out expected %0d got %0d", want[7:0], o_m_tdata[7:0]);
                    errors++;
                end
                if (o_m_tdata[15:8] !== want[15:8]) begin
                    $error("green_out expected %0d got %0d", want[15:8], o_m_tdata[15:8]);
                    errors++;
                end
                if (o_m_tdata[23:16] !== want[23:16]) begin
                    $error("blue_out expected %0d got %0d", want[23:16], o_m_tdata[23:16]);
                    errors++;
                end
            end
        end
    end

    // timeout guard
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("hsv_component_replace_tb failed");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        logic [23:0] got;
        mode_q = MODE_HUE; hue_q = 9'd0; sat_q = 7'd0; val_q = 7'd100;

        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // after reset: hue forced to 0, so grey/black results are easy to read
        rows = '{
            '{24'h000000, 1, 24'h000000},   // black
            '{24'hFFFFFF, 1, 24'hFFFFFF},   // white, grey pixel
            '{24'h808080, 1, 24'h808080},   // mid grey
            '{24'h0000FF, 1, 24'h0000FF},   // pure red, hue 0 keeps it red
            '{24'h00FF00, 1, 24'h0000FF},
            '{24'hFF0000, 1, 24'h0000FF},
            '{24'h00FFFF, 0, 24'h0},        // max tie red/green
            '{24'hFF00FF, 0, 24'h0},
            '{24'hFFFF00, 0, 24'h0},
            '{24'h010200, 0, 24'h0},
            '{24'hFE01FF, 0, 24'h0},
            '{24'h55AA01, 0, 24'h0}
        };
        foreach (rows[i]) begin
            if (rows[i].known) begin
                got = replace_pixel(rows[i].rgb);
                if (got !== rows[i].out) begin
                    $error("predictor row %0d expected %h got %h", i, rows[i].out, got);
                    errors++;
                end
            end
            send_pixel(rows[i].rgb);
        end
        drain();

        // every mode, extremes of every register, out-of-range writes clamp
        for (int m = 0; m < 4; m++) begin
            write_reg(CFG_MODE, 9'(m));
            for (int e = 0; e < 3; e++) begin
                write_reg(CFG_HUE, e == 0 ? 9'd0 : e == 1 ? 9'd359 : 9'd511);
                write_reg(CFG_SAT, e == 0 ? 9'd0 : e == 1 ? 9'd100 : 9'h1FF);
                write_reg(CFG_VAL, e == 0 ? 9'd0 : e == 1 ? 9'd100 : 9'd127);
                foreach (rows[i]) send_pixel(rows[i].rgb);
                drain();
            end
        end

        // random phases with random register settings
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(CFG_MODE, 9'($urandom_range(0, 3)));
            write_reg(CFG_HUE, 9'($urandom));
            write_reg(CFG_SAT, 9'($urandom_range(0, 127)));
            write_reg(CFG_VAL, 9'($urandom_range(0, 127)));
            if (ph == 3) begin
                // long receiver hold-off while pixels keep coming
                fork
                    begin
                        hold_off = 1;
                        repeat (200) @(negedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            if (ph >= 10) calm = 1;
            for (int k = 0; k < 100; k++) send_pixel(rand_pixel());
            drain();
        end

        if (errors == 0)
            $display("hsv_component_replace_tb passed");
        else
            $display("hsv_component_replace_tb failed");
        $finish;
    end
endmodule
